### design/lcss_pkg.sv
// Shared types, constants and curve-table functions for the log curve sample shaper.
`timescale 1ns / 1ps

package lcss_pkg;

   localparam int unsigned SAMPLE_W   = 16;
   localparam int unsigned GAIN_W     = 16;
   localparam int unsigned MAG_W      = 17;
   localparam int unsigned PROD_W     = MAG_W + GAIN_W;
   localparam int unsigned CURVE_W    = 15;
   localparam int unsigned FRAC_W     = 8;
   localparam int unsigned CSR_IDX_W  = 8;
   localparam int unsigned CSR_DATA_W = 16;

   localparam int unsigned FULL_SCALE = 32'h0000_7FFF;
   localparam int unsigned MAG_MAX    = 32768;
   localparam int unsigned ROUND_HALF = 128;

   localparam int unsigned       LOG_FRAC_BITS   = 24;
   localparam longint unsigned   CURVE_SCALE_Q16 = 64'd646437265;

   localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE     = 8'd0,
      CSR_INPUT_GAIN = 8'd1
   } csr_reg_type;

   // Control that rides along with every sample through the pipe
   typedef struct packed {
      logic                bypass;
      logic                neg;
      logic [SAMPLE_W-1:0] raw;
   } side_type;

   // log2 of v with 24 fraction bits, by repeated squaring of a Q1.30 mantissa
   function automatic logic [63:0] log2_q24(input logic [31:0] v);
      logic [31:0] e;
      logic [63:0] m;
      logic [63:0] frac;
      e    = '0;
      frac = '0;
      for (int b = 0; b < 32; b++) begin
         if (v[b]) e = 32'(b);
      end
      m = 64'(v) << (32'd30 - e);
      for (int k = 0; k < LOG_FRAC_BITS; k++) begin
         m    = (m * m) >> 30;
         frac = frac << 1;
         if (m >= 64'h0000_0000_8000_0000) begin
            m    = m >> 1;
            frac = frac | 64'd1;
         end
      end
      if (v == '0) return '0;
      return (64'(e) << LOG_FRAC_BITS) | frac;
   endfunction

   // Curve entry i for a table of the given number of points
   function automatic logic [CURVE_W-1:0] curve_entry(input int unsigned points,
                                                      input int unsigned i);
      logic [63:0] base;
      logic [63:0] lv;
      logic [63:0] d;
      logic [63:0] val;
      base = log2_q24(32'(points));
      lv   = log2_q24(32'(points + 9 * i));
      d    = (lv >= base) ? (lv - base) : 64'd0;
      val  = (d * CURVE_SCALE_Q16 + (64'd1 << 39)) >> 40;
      if (val > 64'(FULL_SCALE)) val = 64'(FULL_SCALE);
      return val[CURVE_W-1:0];
   endfunction

endpackage

### design/lcss_ifs.sv
// Channel interfaces: sample request, sample response and register write.
`timescale 1ns / 1ps

interface lcss_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] in_sample;
   modport source (output valid, output in_sample, input ready);
   modport sink   (input valid, input in_sample, output ready);
endinterface

interface lcss_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_sample;
   modport source (output valid, output out_sample, input ready);
   modport sink   (input valid, input out_sample, output ready);
endinterface

interface lcss_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [15:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### design/log_curve_sample_shaper_unit.sv
// Throughput: one sample per cycle while rsp is not stalled; every stage holds its own valid bit,
//   so a stalled output backs up one stage at a time and bubbles are squeezed out.
// The rate is set by the eight-stage pipe: gain multiply, position multiply, ROM read.
// Reset (synchronous, active high) empties the pipe, sets enable to 1 and gain to unity;
//   the curve ROM is constant and needs no fill.
`timescale 1ns / 1ps

module log_curve_sample_shaper_unit
   import lcss_pkg::*;
#(
   parameter int unsigned TABLE_POINTS = 256
)
(
   input  logic        clock,
   input  logic        reset,
   lcss_req_if.sink    req_bus,
   lcss_rsp_if.source  rsp_bus,
   lcss_csr_if.sink    csr_bus
);

   localparam int unsigned IDX_W = $clog2(TABLE_POINTS);

   // Configuration registers; to be written only while the pipe is drained (the user's duty, not enforced here)
   logic              enable_ff;
   logic [GAIN_W-1:0] gain_ff;

   // Beats between the three pipe sections
   logic              g_valid, g_ready;
   logic [PROD_W-1:0] g_prod;
   side_type          g_side;

   logic              p_valid, p_ready;
   logic [IDX_W-1:0]  p_addr_lo, p_addr_hi;
   logic [FRAC_W-1:0] p_frac;
   side_type          p_side;

   logic [SAMPLE_W-1:0] rsp_sample;

   // Register port never stalls
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
         gain_ff   <= GAIN_UNITY;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_ENABLE: begin
               enable_ff <= csr_bus.data[0];
            end
            CSR_INPUT_GAIN: begin
               gain_ff <= csr_bus.data[GAIN_W-1:0];
            end
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   // Stages 1-2: magnitude, then magnitude times gain
   lcss_gain u_gain (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .in_sample  (req_bus.in_sample),
      .enable     (enable_ff),
      .input_gain (gain_ff),
      .out_valid  (g_valid),
      .out_ready  (g_ready),
      .out_prod   (g_prod),
      .out_side   (g_side)
   );

   // Stages 3-5: round and saturate, scale by the table span, divide by full scale
   lcss_position #(
      .TABLE_POINTS (TABLE_POINTS)
   ) u_position (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (g_valid),
      .in_ready    (g_ready),
      .in_prod     (g_prod),
      .in_side     (g_side),
      .out_valid   (p_valid),
      .out_ready   (p_ready),
      .out_addr_lo (p_addr_lo),
      .out_addr_hi (p_addr_hi),
      .out_frac    (p_frac),
      .out_side    (p_side)
   );

   // Stages 6-8: ROM read, blend, sign restore into the output register
   lcss_curve #(
      .TABLE_POINTS (TABLE_POINTS)
   ) u_curve (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (p_valid),
      .in_ready   (p_ready),
      .in_addr_lo (p_addr_lo),
      .in_addr_hi (p_addr_hi),
      .in_frac    (p_frac),
      .in_side    (p_side),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_sample (rsp_sample)
   );

   assign rsp_bus.out_sample = rsp_sample;

endmodule

### design/lcss_gain.sv
// Gain front end: sign split and magnitude times Q8.8 gain, two register stages.
`timescale 1ns / 1ps

module lcss_gain
   import lcss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [SAMPLE_W-1:0] in_sample,
   input  logic                enable,
   input  logic [GAIN_W-1:0]   input_gain,
   output logic                out_valid,
   input  logic                out_ready,
   output logic [PROD_W-1:0]   out_prod,
   output side_type            out_side
);

   logic                v1_ff, v2_ff;
   logic                rdy1, rdy2;
   logic [MAG_W-1:0]    mag_in, mag_ff;
   side_type            side1_in, side1_ff, side2_ff;
   logic [PROD_W-1:0]   prod_in, prod_ff;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      side1_in.bypass = !enable;
      side1_in.neg    = in_sample[SAMPLE_W-1];
      side1_in.raw    = in_sample;
      mag_in = in_sample[SAMPLE_W-1] ? (MAG_W'(MAG_MAX) * 2'd2 - {1'b0, in_sample})
                                     : {1'b0, in_sample};
      prod_in = PROD_W'(mag_ff) * PROD_W'(input_gain);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         mag_ff   <= mag_in;
         side1_ff <= side1_in;
      end
      if (rdy2 && v1_ff) begin
         prod_ff  <= prod_in;
         side2_ff <= side1_ff;
      end
   end

   assign out_valid = v2_ff;
   assign out_prod  = prod_ff;
   assign out_side  = side2_ff;

endmodule

### design/lcss_position.sv
// Round and saturate the gained value, then scale it to a table index and fraction.
`timescale 1ns / 1ps

module lcss_position
   import lcss_pkg::*;
#(
   parameter int unsigned TABLE_POINTS = 256
)
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [PROD_W-1:0]                in_prod,
   input  side_type                         in_side,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [$clog2(TABLE_POINTS)-1:0]  out_addr_lo,
   output logic [$clog2(TABLE_POINTS)-1:0]  out_addr_hi,
   output logic [FRAC_W-1:0]                out_frac,
   output side_type                         out_side
);

   localparam int unsigned     IDX_W   = $clog2(TABLE_POINTS);
   localparam longint unsigned SCALE_K = longint'(TABLE_POINTS - 1) * 256;
   localparam longint unsigned X_MAX   = SCALE_K * longint'(MAG_MAX);
   localparam int unsigned     X_W     = $clog2(X_MAX + 1);
   localparam int unsigned     A_W     = X_W - 15;
   localparam int unsigned     Y_W     = ((A_W > 15) ? A_W : 15) + 1;
   localparam int unsigned     Q_W     = X_W - 14;
   localparam int unsigned     I_W     = Q_W - FRAC_W;
   localparam logic [X_W-1:0]  K_X     = X_W'(SCALE_K);
   localparam logic [IDX_W-1:0] LAST   = IDX_W'(TABLE_POINTS - 1);

   logic                v1_ff, v2_ff, v3_ff;
   logic                rdy1, rdy2, rdy3;
   side_type            side1_ff, side2_ff, side3_ff;

   logic [PROD_W-8:0]   rounded;
   logic [PROD_W-8:0]   limit;
   logic [SAMPLE_W-1:0] g_in, g_ff;
   logic [X_W-1:0]      x_in, x_ff;

   logic [A_W-1:0]      a_part;
   logic [Y_W-1:0]      y_sum;
   logic [15:0]         r_sum;
   logic                corr;
   logic [Q_W-1:0]      q_pos;
   logic [I_W-1:0]      idx;
   logic                clamp;
   logic [IDX_W-1:0]    addr_lo_in, addr_lo_ff;
   logic [IDX_W-1:0]    addr_hi_in, addr_hi_ff;
   logic [FRAC_W-1:0]   frac_in, frac_ff;

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      // round half away from zero on the magnitude, clip to the signed range
      rounded = (PROD_W-7)'((in_prod + PROD_W'(ROUND_HALF)) >> 8);
      limit   = in_side.neg ? (PROD_W-7)'(MAG_MAX) : (PROD_W-7)'(FULL_SCALE);
      g_in    = (rounded > limit) ? limit[SAMPLE_W-1:0] : rounded[SAMPLE_W-1:0];

      x_in = K_X * X_W'(g_ff);

      // divide by 2^15-1: x = a*32767 + (a+b), folded twice
      a_part = x_ff[X_W-1:15];
      y_sum  = Y_W'(a_part) + Y_W'(x_ff[14:0]);
      r_sum  = 16'(y_sum[Y_W-1:15]) + 16'(y_sum[14:0]);
      corr   = (r_sum >= 16'(FULL_SCALE));
      q_pos  = Q_W'(a_part) + Q_W'(y_sum[Y_W-1:15]) + Q_W'(corr);
      idx    = q_pos[Q_W-1:FRAC_W];
      clamp  = (idx >= I_W'(TABLE_POINTS - 1));

      addr_lo_in = clamp ? LAST : idx[IDX_W-1:0];
      addr_hi_in = clamp ? LAST : idx[IDX_W-1:0] + 1'b1;
      frac_in    = clamp ? '0 : q_pos[FRAC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         g_ff     <= g_in;
         side1_ff <= in_side;
      end
      if (rdy2 && v1_ff) begin
         x_ff     <= x_in;
         side2_ff <= side1_ff;
      end
      if (rdy3 && v2_ff) begin
         addr_lo_ff <= addr_lo_in;
         addr_hi_ff <= addr_hi_in;
         frac_ff    <= frac_in;
         side3_ff   <= side2_ff;
      end
   end

   assign out_valid   = v3_ff;
   assign out_addr_lo = addr_lo_ff;
   assign out_addr_hi = addr_hi_ff;
   assign out_frac    = frac_ff;
   assign out_side    = side3_ff;

endmodule

### design/lcss_curve.sv
// Curve ROM lookup, linear blend of neighbor entries and sign restore.
`timescale 1ns / 1ps

module lcss_curve
   import lcss_pkg::*;
#(
   parameter int unsigned TABLE_POINTS = 256
)
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [$clog2(TABLE_POINTS)-1:0]  in_addr_lo,
   input  logic [$clog2(TABLE_POINTS)-1:0]  in_addr_hi,
   input  logic [FRAC_W-1:0]                in_frac,
   input  side_type                         in_side,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic [SAMPLE_W-1:0]              out_sample
);

   // entries stay below 2^15, so the weighted sum stays below 2^23
   localparam int unsigned BLEND_W = CURVE_W + FRAC_W;

   logic [CURVE_W-1:0]  curve_rom [TABLE_POINTS];

   logic                v1_ff, v2_ff, v3_ff;
   logic                rdy1, rdy2, rdy3;
   side_type            side1_ff, side2_ff;
   logic [CURVE_W-1:0]  lo_ff, hi_ff;
   logic [FRAC_W-1:0]   frac_ff;
   logic [BLEND_W-1:0]  blend;
   logic [CURVE_W-1:0]  shaped_in, shaped_ff;
   logic [SAMPLE_W-1:0] res_in, res_ff;

   for (genvar gi = 0; gi < TABLE_POINTS; gi++) begin : g_rom
      assign curve_rom[gi] = curve_entry(TABLE_POINTS, gi);
   end

   assign rdy3     = !v3_ff || out_ready;
   assign rdy2     = !v2_ff || rdy3;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;

   always_comb begin
      blend = BLEND_W'(lo_ff) * BLEND_W'((FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(frac_ff))
            + BLEND_W'(hi_ff) * BLEND_W'(frac_ff);
      shaped_in = blend[CURVE_W+FRAC_W-1:FRAC_W];
      if (side2_ff.bypass) begin
         res_in = side2_ff.raw;
      end else if (side2_ff.neg) begin
         res_in = SAMPLE_W'(0) - SAMPLE_W'(shaped_ff);
      end else begin
         res_in = SAMPLE_W'(shaped_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= in_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && in_valid) begin
         lo_ff    <= curve_rom[in_addr_lo];
         hi_ff    <= curve_rom[in_addr_hi];
         frac_ff  <= in_frac;
         side1_ff <= in_side;
      end
      if (rdy2 && v1_ff) begin
         shaped_ff <= shaped_in;
         side2_ff  <= side1_ff;
      end
      if (rdy3 && v2_ff) begin
         res_ff <= res_in;
      end
   end

   assign out_valid  = v3_ff;
   assign out_sample = res_ff;

endmodule

### dv/log_curve_shaper_checker.sv
// Checker for the log curve sample shaper: watches all three channels and predicts every response.
`timescale 1ns / 1ps

module log_curve_shaper_checker
   import lcss_pkg::*;
#(
   parameter int unsigned TABLE_POINTS = 256
)
(
   input  logic        clock,
   input  logic        reset,
   lcss_req_if         req_mon,
   lcss_rsp_if         rsp_mon,
   lcss_csr_if         csr_mon,
   output int unsigned mismatches,
   output int unsigned outstanding,
   output int unsigned checked
);

   logic [CURVE_W-1:0]  curve_ref [TABLE_POINTS];
   logic                enable_q;
   logic [GAIN_W-1:0]   gain_q;
   logic [SAMPLE_W-1:0] expected_samples [$];

   // log2 with 24 fraction bits: the integer part is the top set bit, the fraction
   // comes from squaring a Q1.30 mantissa and watching it cross 2.0
   function automatic longint unsigned log2_fixed(input int unsigned v);
      int unsigned       top_bit;
      longint unsigned   mant;
      longint unsigned   bits;
      top_bit = 0;
      bits    = 0;
      while ((v >> (top_bit + 1)) != 0) top_bit++;
      mant = longint'(v) << (30 - top_bit);
      repeat (LOG_FRAC_BITS) begin
         mant = (mant * mant) >> 30;
         bits = bits << 1;
         if (mant >= (64'd1 << 31)) begin
            mant = mant >> 1;
            bits = bits | 64'd1;
         end
      end
      return (longint'(top_bit) << LOG_FRAC_BITS) | bits;
   endfunction

   // Expected output for one accepted input beat under the current register values
   function automatic logic [SAMPLE_W-1:0] shape_expected(input logic [SAMPLE_W-1:0] raw);
      logic            neg;
      longint unsigned mag;
      longint unsigned gained;
      longint unsigned pos;
      longint unsigned idx;
      longint unsigned frac;
      longint unsigned shaped;
      if (!enable_q) return raw;
      neg    = raw[SAMPLE_W-1];
      mag    = neg ? (64'd65536 - 64'(raw)) : 64'(raw);
      gained = (mag * 64'(gain_q) + ROUND_HALF) >> FRAC_W;
      if (neg && gained > MAG_MAX) gained = MAG_MAX;
      if (!neg && gained > FULL_SCALE) gained = FULL_SCALE;
      pos  = (64'(TABLE_POINTS - 1) * gained * 256) / FULL_SCALE;
      idx  = pos >> FRAC_W;
      frac = pos & 64'hFF;
      if (idx >= TABLE_POINTS - 1)
         shaped = curve_ref[TABLE_POINTS-1];
      else
         shaped = (64'(curve_ref[idx]) * (256 - frac) + 64'(curve_ref[idx+1]) * frac) >> FRAC_W;
      return neg ? SAMPLE_W'(64'd0 - shaped) : SAMPLE_W'(shaped);
   endfunction

   initial begin
      longint unsigned base;
      longint unsigned delta;
      longint unsigned entry;
      base = log2_fixed(TABLE_POINTS);
      for (int unsigned i = 0; i < TABLE_POINTS; i++) begin
         delta = log2_fixed(TABLE_POINTS + 9 * i) - base;
         entry = (delta * CURVE_SCALE_Q16 + (64'd1 << 39)) >> 40;
         if (entry > FULL_SCALE) entry = FULL_SCALE;
         curve_ref[i] = entry[CURVE_W-1:0];
      end
   end

   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] want;
      if (reset) begin
         enable_q   = 1'b1;
         gain_q     = GAIN_UNITY;
         mismatches = 0;
         checked    = 0;
         expected_samples.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_ENABLE:     enable_q = csr_mon.data[0];
               CSR_INPUT_GAIN: gain_q   = csr_mon.data;
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            expected_samples.push_back(shape_expected(req_mon.in_sample));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_samples.size() == 0) begin
               mismatches++;
               $error("unexpected rsp beat: out_sample %0d", rsp_mon.out_sample);
            end else begin
               want = expected_samples.pop_front();
               checked++;
               if (rsp_mon.out_sample !== want) begin
                  mismatches++;
                  $error("out_sample: expected %0d, actual %0d",
                         $signed(want), rsp_mon.out_sample);
               end
            end
         end
      end
      outstanding = expected_samples.size();
   end

endmodule

### dv/log_curve_sample_shaper_unit_test.sv
// Top of the shaper testbench: clock, reset, stimulus, stall patterns and the verdict.
`timescale 1ns / 1ps

module log_curve_sample_shaper_unit_test
   import lcss_pkg::*;
();

   localparam int unsigned TABLE_POINTS   = 256;
   localparam int unsigned NUM_PHASES     = 10;
   localparam int unsigned PHASE_SAMPLES  = 150;
   localparam int unsigned BACKLOG_BEATS  = 48;
   localparam int unsigned LONG_HOLDOFF   = 300;
   localparam int unsigned IDLE_LIMIT     = 3000;
   localparam int unsigned DRAIN_CYCLES   = 24;

   // An index that decodes to no register; writes to it must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED_IDX = 8'h5A;

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_HALF,
      RX_SPARSE,
      RX_PERIODIC
   } rx_mode_type;

   logic clock;
   logic reset;

   lcss_req_if req_bus ();
   lcss_rsp_if rsp_bus ();
   lcss_csr_if csr_bus ();

   int unsigned mismatches;
   int unsigned outstanding;
   int unsigned checked;
   int unsigned samples_sent = 0;
   int unsigned csr_writes   = 0;

   // Set by the stimulus to ask the receiver for its one long hold-off
   logic long_holdoff_pending = 1'b0;

   log_curve_sample_shaper_unit #(
      .TABLE_POINTS (TABLE_POINTS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   log_curve_shaper_checker #(
      .TABLE_POINTS (TABLE_POINTS)
   ) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .csr_mon     (csr_bus),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one sample and hold it until the block takes it. Valid stays high on
   // return so that back-to-back beats follow without a gap.
   task automatic send_sample(input logic [SAMPLE_W-1:0] value);
      req_bus.valid     <= 1'b1;
      req_bus.in_sample <= value;
      do @(posedge clock); while (!req_bus.ready);
      samples_sent++;
   endtask

   // Write one register, then drop valid
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
      csr_writes++;
   endtask

   // Stop offering and hold until every predicted response has come back;
   // sample the count mid-cycle so the checker's update at the edge cannot race us
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   // Mix of corner values, small magnitudes, near full scale and plain random words
   function automatic logic [SAMPLE_W-1:0] random_sample();
      logic [SAMPLE_W-1:0] mag;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0:       return 16'h8000;
               1:       return 16'h7FFF;
               2:       return 16'h0000;
               3:       return 16'hFFFF;
               default: return 16'h0001;
            endcase
         end
         1, 2:    mag = 16'($urandom_range(0, 700));
         3:       mag = 16'($urandom_range(32000, 32767));
         default: return 16'($urandom);
      endcase
      return $urandom_range(0, 1) ? (~mag + 16'd1) : mag;
   endfunction

   // Send a run of random samples in bursts; a gapless run never drops valid
   task automatic send_random_run(input int unsigned count, input bit gapless);
      int unsigned left;
      int unsigned burst;
      left = count;
      while (left != 0) begin
         burst = $urandom_range(1, 24);
         if (burst > left) burst = left;
         repeat (burst) send_sample(random_sample());
         left -= burst;
         if (!gapless && left != 0 && $urandom_range(0, 2) != 0) begin
            req_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   endtask

   // Receiver: pick a stall pattern for a random stretch, then another; honor one
   // long hold-off on request so the pipe fills and back-pressures the input
   initial begin : rsp_stall_pattern
      rx_mode_type mode;
      int unsigned seg_left;
      int unsigned tick;
      bit          holdoff_served;
      mode           = RX_ALWAYS;
      seg_left       = 0;
      tick           = 0;
      holdoff_served = 1'b0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (long_holdoff_pending && !holdoff_served) begin
            holdoff_served = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLDOFF) @(posedge clock);
         end
         if (seg_left == 0) begin
            mode     = rx_mode_type'($urandom_range(0, 3));
            seg_left = $urandom_range(16, 160);
         end
         seg_left--;
         tick++;
         case (mode)
            RX_ALWAYS:   rsp_bus.ready <= 1'b1;
            RX_HALF:     rsp_bus.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            RX_PERIODIC: rsp_bus.ready <= tick[2];
            default:     rsp_bus.ready <= 1'b1;
         endcase
      end
   end

   // Watchdog: end the run if no channel moves a beat for too long
   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
             || (csr_bus.valid && csr_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $error("no beat accepted for %0d cycles", IDLE_LIMIT);
      $display("log_curve_sample_shaper_unit_test: errors");
      $finish;
   end

   initial begin : stimulus
      logic              phase_enable;
      logic [GAIN_W-1:0] phase_gain;

      req_bus.valid     = 1'b0;
      req_bus.in_sample = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_ENABLE;
      csr_bus.data      = '0;
      reset             = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset values: unity gain with the curve on. Cover zero, both extremes,
      // the most negative value (clamped past the last entry), a position that
      // lands on an entry with zero fraction (+-257), and one near the end.
      send_sample(16'h0000);
      send_sample(16'h0001);
      send_sample(16'hFFFF);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h4000);
      send_sample(16'hC000);
      send_sample(16'd257);
      send_sample(~16'd257 + 16'd1);
      send_sample(16'd32640);
      send_sample(16'd12345);
      wait_drained();

      // Half gain: check rounding half away from zero on both signs
      write_csr(CSR_INPUT_GAIN, 16'd128);
      send_sample(16'd1);
      send_sample(16'hFFFF);
      send_sample(16'd3);
      send_sample(16'hFFFD);
      wait_drained();

      // Largest gain: saturate both ways
      write_csr(CSR_INPUT_GAIN, 16'hFFFF);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'd200);
      send_sample(~16'd200 + 16'd1);
      wait_drained();

      // A write to a dead index changes nothing; enable sees only its low bit
      write_csr(CSR_UNUSED_IDX, 16'h0000);
      write_csr(CSR_ENABLE, 16'hFFFE);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h1234);
      wait_drained();

      // Random phases, each under its own register setting
      for (int unsigned p = 0; p < NUM_PHASES; p++) begin
         phase_enable = 1'b1;
         case (p)
            0:       phase_gain = GAIN_UNITY;
            1:       phase_gain = '0;
            2:       phase_gain = 16'hFFFF;
            3: begin
               phase_enable = 1'b0;
               phase_gain   = 16'($urandom);
            end
            4:       phase_gain = 16'($urandom_range(0, 1023));
            default: begin
               phase_enable = ($urandom_range(0, 4) != 0);
               phase_gain   = $urandom_range(0, 1) ? 16'($urandom)
                                                   : 16'($urandom_range(192, 320));
            end
         endcase
         write_csr(CSR_ENABLE, {15'($urandom), phase_enable});
         write_csr(CSR_INPUT_GAIN, phase_gain);

         // Once, stall the receiver for a long stretch while beats keep coming,
         // so the pipe fills up and req.ready drops
         if (p == 5) begin
            long_holdoff_pending = 1'b1;
            repeat (BACKLOG_BEATS) send_sample(random_sample());
         end

         send_random_run(PHASE_SAMPLES, (p % 3) == 0);
         wait_drained();
      end

      // Give any stray response time to show up
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (outstanding != 0)
         $error("%0d predicted responses never arrived", outstanding);
      $display("Run covered %0d samples and %0d register writes; %0d responses compared,",
               samples_sent, csr_writes, checked);
      $display("including gain saturation, bypass, a long output stall and full drains.");
      if (mismatches == 0 && outstanding == 0)
         $display("log_curve_sample_shaper_unit_test: clean");
      else
         $display("log_curve_sample_shaper_unit_test: errors");
      $finish;
   end

endmodule
